// ----- rtl/gmav_pkg.sv -----
// ----------------------------------------------------------------------------
// gmav_pkg
// Shared constants, controller states and control/status structs for the
// gated moving average with idle detection.
// ----------------------------------------------------------------------------
package gmav_pkg;

    // default configuration of the filter
    localparam int WINDOW_DEF      = 30;
    localparam int SAMPLE_BITS_DEF = 20;

    // register reset value and idle run saturation
    localparam int LIMIT_BITS             = 8;
    localparam logic [7:0] IDLE_LIMIT_RST = 8'd50;
    localparam logic [7:0] IDLE_RUN_SAT   = 8'hFF;

    // raw value of 1.0 with 8 fraction bits
    localparam int ONE_RAW = 256;

    // controller states
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_CLASSIFY,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } gmav_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic classify;
        logic accum;
        logic div_load;
        logic div_step;
        logic emit;
    } gmav_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pos;
        logic div_last;
        logic out_free;
    } gmav_status_t;

endpackage

// ----- rtl/gmav_if.sv -----
// ----------------------------------------------------------------------------
// gmav channel interfaces
// Valid/ready channels for samples, results and the idle limit register.
// ----------------------------------------------------------------------------
interface gmav_sample_if #(
    parameter int W = gmav_pkg::SAMPLE_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rate_sample;

    modport source (output valid, output rate_sample, input ready);
    modport sink   (input valid, input rate_sample, output ready);
endinterface

interface gmav_result_if #(
    parameter int W = gmav_pkg::SAMPLE_BITS_DEF - 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] average_rate;
    logic         idle;

    modport source (output valid, output average_rate, output idle, input ready);
    modport sink   (input valid, input average_rate, input idle, output ready);
endinterface

interface gmav_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] idle_limit;

    modport source (output valid, output idle_limit, input ready);
    modport sink   (input valid, input idle_limit, output ready);
endinterface

// ----- rtl/gated_moving_average_idle_detect.sv -----
// ----------------------------------------------------------------------------
// gated_moving_average_idle_detect
// Boxcar average of positive angular-rate samples with idle gating.
// ----------------------------------------------------------------------------
// Channels: sample_ch takes one signed rate sample (8 fraction bits) per item;
// result_ch returns exactly one item per sample with average_rate and idle;
// cfg writes the idle limit and is always ready, to be used while no item
// is in flight.
// A sample under 1.0 in magnitude advances the idle run; once the run reaches
// the limit the result is idle with a zero average. A sample of 1.0 or more
// enters the window and a new average is computed; a sample of -1.0 or less
// only clears the idle run.
// Sequence: an idle or negative sample passes WAIT, CLASSIFY and EMIT; a
// sample entering the window also passes ACCUM, DIV_LOAD and DIVIDE, where
// the bit-serial restoring divider makes one quotient bit per cycle; EMIT
// waits for a free output register. One item is in work at a time, the next
// is accepted in the cycle after its result is loaded into the output
// register, so a stalled receiver holds at most one finished result while the
// block waits for the next sample.
// Reset clears the window, the running sum, the held average and the idle run
// and sets the idle limit to 50; ring contents need no clearing.
// ----------------------------------------------------------------------------
module gated_moving_average_idle_detect #(
    parameter int WINDOW      = gmav_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = gmav_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gmav_cfg_if.sink      cfg,
    gmav_sample_if.sink   sample_ch,
    gmav_result_if.source result_ch
);
    import gmav_pkg::*;

    gmav_cmd_t    cmd;
    gmav_status_t status;
    logic         sample_ready;

    assign sample_ch.ready = sample_ready;

    // sequencer
    gmav_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic and storage
    gmav_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rate_sample (sample_ch.rate_sample),
        .cfg         (cfg),
        .result_ch   (result_ch),
        .cmd         (cmd),
        .status      (status)
    );

    // an idle result always carries a zero average
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.idle |-> result_ch.average_rate == '0)
        else $error("idle result with nonzero average");

    // only one item is in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready |=> !sample_ch.ready)
        else $error("sample accepted while previous item in work");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.classify, cmd.accum, cmd.div_load,
                  cmd.div_step, cmd.emit}))
        else $error("conflicting datapath commands");

    // a result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !result_ch.valid || result_ch.ready)
        else $error("result overwritten before taken");

endmodule

// ----- rtl/gmav_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmav_ctrl
// Sequencer: takes one sample, classifies it, runs the window update and
// the serial divide for rising samples, then hands the result out.
// ----------------------------------------------------------------------------
module gmav_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  gmav_pkg::gmav_status_t status,
    output gmav_pkg::gmav_cmd_t    cmd
);
    import gmav_pkg::*;

    gmav_state_t state_reg;
    gmav_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = status.is_pos ? ST_ACCUM : ST_EMIT;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

endmodule

// ----- rtl/gmav_dp.sv -----
// ----------------------------------------------------------------------------
// gmav_dp
// Datapath: idle run counter, sample ring, running sum, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module gmav_dp #(
    parameter int WINDOW      = gmav_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = gmav_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] rate_sample,
    gmav_cfg_if.sink                      cfg,
    gmav_result_if.source                 result_ch,
    input  gmav_pkg::gmav_cmd_t           cmd,
    output gmav_pkg::gmav_status_t        status
);
    import gmav_pkg::*;

    localparam int AVG_W  = SAMPLE_BITS - 1;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = AVG_W + $clog2(WINDOW);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic signed [SAMPLE_BITS-1:0] POS_ONE = SAMPLE_BITS'(ONE_RAW);
    localparam logic signed [SAMPLE_BITS-1:0] NEG_ONE = -POS_ONE;

    // sample ring
    logic [AVG_W-1:0] ring [WINDOW];
    logic [AVG_W-1:0] ring_rd_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [7:0]        idle_limit_reg;
    logic [7:0]        idle_run_reg;
    logic [7:0]        idle_run_next;
    logic              pos_reg;
    logic              res_idle_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [AVG_W-1:0]  held_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              ring_full;
    logic              is_idle;
    logic              out_valid_reg;
    logic [AVG_W-1:0]  out_avg_reg;
    logic              out_idle_reg;
    logic [AVG_W-1:0]  quot_avg;

    // sample classification
    assign is_idle   = (sample_reg > NEG_ONE) && (sample_reg < POS_ONE);
    assign ring_full = (fill_count_reg == CNT_W'(WINDOW));
    assign quot_avg  = quot_reg[AVG_W-1:0];

    assign idle_run_next = (idle_run_reg == IDLE_RUN_SAT) ? IDLE_RUN_SAT
                                                          : idle_run_reg + 8'd1;

    // window sum update
    always_comb
    begin
        if (ring_full)
        begin
            sum_next = sum_reg - SUM_W'(ring_rd_reg)
                       + SUM_W'(sample_reg[AVG_W-1:0]);
        end
        else
        begin
            sum_next = sum_reg + SUM_W'(sample_reg[AVG_W-1:0]);
        end
    end

    // restoring divide step
    assign trial     = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, fill_count_reg};

    assign status.is_pos   = (sample_reg >= POS_ONE);
    assign status.div_last = (div_cnt_reg == DCNT_W'(1));
    assign status.out_free = !out_valid_reg || result_ch.ready;

    assign cfg.ready              = 1'b1;
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.average_rate = out_avg_reg;
    assign result_ch.idle         = out_idle_reg;

    // ring write and registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            ring[write_slot_reg] <= sample_reg[AVG_W-1:0];
        end
        ring_rd_reg <= ring[write_slot_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= rate_sample;
        end
        if (cmd.emit)
        begin
            out_idle_reg <= res_idle_reg && !pos_reg;
            if (pos_reg)
            begin
                out_avg_reg <= quot_avg;
            end
            else if (res_idle_reg)
            begin
                out_avg_reg <= '0;
            end
            else
            begin
                out_avg_reg <= held_reg;
            end
        end
        if (cmd.div_load)
        begin
            quot_reg <= sum_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial_sub[CNT_W])
            begin
                rem_reg  <= trial_sub[CNT_W-1:0];
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[CNT_W-1:0];
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // filter state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            idle_run_reg   <= '0;
            pos_reg        <= 1'b0;
            res_idle_reg   <= 1'b0;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            sum_reg        <= '0;
            held_reg       <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                idle_limit_reg <= cfg.idle_limit;
            end

            // idle run and result kind
            if (cmd.classify)
            begin
                pos_reg <= status.is_pos;
                if (is_idle)
                begin
                    idle_run_reg <= idle_run_next;
                    res_idle_reg <= (idle_run_next >= idle_limit_reg);
                end
                else
                begin
                    idle_run_reg <= '0;
                    res_idle_reg <= 1'b0;
                end
            end

            // window bookkeeping
            if (cmd.accum)
            begin
                sum_reg <= sum_next;
                if (!ring_full)
                begin
                    fill_count_reg <= fill_count_reg + CNT_W'(1);
                end
                if (write_slot_reg == SLOT_W'(WINDOW - 1))
                begin
                    write_slot_reg <= '0;
                end
                else
                begin
                    write_slot_reg <= write_slot_reg + SLOT_W'(1);
                end
            end

            // divide step counter
            if (cmd.div_load)
            begin
                div_cnt_reg <= DCNT_W'(SUM_W);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end

            if (cmd.emit && pos_reg)
            begin
                held_reg <= quot_avg;
            end

            // output handshake
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
